FILE: hw/rtl/pthc_pkg.sv
`default_nettype none
package pthc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_LO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HI  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM       = 3'd4;

    // Fixed latencies of the arithmetic units
    localparam int unsigned MUL_LAT = 2;
    localparam int unsigned DIV_LAT = 66;

    // Compensation constants
    localparam logic [63:0] P_T_OFS   = 64'd128000;
    localparam logic [63:0] P_BIAS    = 64'd140737488355328;
    localparam logic [63:0] P_FULL    = 64'd1048576;
    localparam logic [63:0] P_SCALE   = 64'd3125;
    localparam logic [31:0] H_T_OFS   = 32'd76800;
    localparam logic [31:0] H_RND     = 32'd16384;
    localparam logic [31:0] H_MID     = 32'd32768;
    localparam logic [31:0] H_ADD     = 32'd2097152;
    localparam logic [31:0] H_RND2    = 32'd8192;
    localparam logic [31:0] H_MAX     = 32'd419430400;
    localparam logic [31:0] T_RND     = 32'd128;

    // Item handed from the temperature front to the pressure/humidity back
    typedef struct packed {
        logic [31:0] fine_t;
        logic [23:0] temp_c;
        logic [19:0] raw_p;
        logic [15:0] raw_h;
    } t_item;

    function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned n);
        logic signed [31:0] s;
        s = $signed(v);
        return 32'(s >>> n);
    endfunction

    function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned n);
        logic signed [63:0] s;
        s = $signed(v);
        return 64'(s >>> n);
    endfunction

    // Signed division by 2^n, rounding toward zero
    function automatic logic [31:0] tdiv32(input logic [31:0] v, input int unsigned n);
        logic [31:0] b;
        b = v[31] ? v + ((32'd1 << n) - 32'd1) : v;
        return asr32(b, n);
    endfunction

    function automatic logic [63:0] tdiv64(input logic [63:0] v, input int unsigned n);
        logic [63:0] b;
        b = v[63] ? v + ((64'd1 << n) - 64'd1) : v;
        return asr64(b, n);
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/pthc_mul64.sv
`default_nettype none
module pthc_mul64 import pthc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;

    // Form partial products, low 64 bits of the product only
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[31:0] * i_b[31:0];
            r_lh <= i_a[31:0] * i_b[63:32];
            r_hl <= i_a[63:32] * i_b[31:0];
        end
    end

    // Sum partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule
`default_nettype wire

FILE: hw/rtl/pthc_div.sv
`default_nettype none
module pthc_div import pthc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quo
);

    localparam int unsigned STEPS = 64;

    logic [63:0] r_n   [0:STEPS];
    logic [63:0] r_rem [0:STEPS];
    logic [63:0] r_d   [0:STEPS];
    logic        r_neg [0:STEPS];
    logic [63:0] r_q;
    logic [63:0] n_n   [1:STEPS];
    logic [63:0] n_rem [1:STEPS];

    // One restoring step per stage
    always_comb begin
        for (int k = 1; k <= STEPS; k++) begin
            logic [64:0] trial;
            logic        ge;
            trial    = {r_rem[k-1], r_n[k-1][63]};
            ge       = trial >= {1'b0, r_d[k-1]};
            n_rem[k] = ge ? 64'(trial - {1'b0, r_d[k-1]}) : trial[63:0];
            n_n[k]   = {r_n[k-1][62:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Take magnitudes and quotient sign
            r_n[0]   <= i_num[63] ? 64'd0 - i_num : i_num;
            r_d[0]   <= i_den[63] ? 64'd0 - i_den : i_den;
            r_rem[0] <= '0;
            r_neg[0] <= i_num[63] ^ i_den[63];
            // Advance the step stages
            for (int k = 1; k <= STEPS; k++) begin
                r_n[k]   <= n_n[k];
                r_rem[k] <= n_rem[k];
                r_d[k]   <= r_d[k-1];
                r_neg[k] <= r_neg[k-1];
            end
            // Restore sign
            r_q <= r_neg[STEPS] ? 64'd0 - r_n[STEPS] : r_n[STEPS];
        end
    end

    assign o_quo = r_q;

endmodule
`default_nettype wire

FILE: hw/rtl/pthc_fifo.sv
`default_nettype none
module pthc_fifo import pthc_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nempty,
    output t_item o_item
);

    // DEPTH must be a power of two so that the pointers wrap on their own; the block does not enforce it
    localparam int unsigned AW = $clog2(DEPTH);

    t_item          r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_count;

    assign o_full   = (r_count == (AW+1)'(DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_item   = r_mem[r_rp];

    // Store item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH)) else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_nempty |-> !i_pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hw/rtl/pthc_front.sv
`default_nettype none
module pthc_front import pthc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_raw_t,
    input  logic [19:0] i_raw_p,
    input  logic [15:0] i_raw_h,
    input  logic [47:0] i_temp_coeffs,
    output logic        o_push,
    input  logic        i_full,
    output t_item       o_item
);

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] t3;
    logic [31:0] ta;
    logic [31:0] tb;
    logic [31:0] tf;
    logic [31:0] tc;
    logic        en;

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic [31:0] r1_am;
    logic [31:0] r1_bsq;
    logic [19:0] r1_p;
    logic [15:0] r1_h;
    logic [31:0] r2_a;
    logic [31:0] r2_bm;
    logic [19:0] r2_p;
    logic [15:0] r2_h;
    t_item       r3_item;

    assign t1 = {16'd0, i_temp_coeffs[15:0]};
    assign t2 = {{16{i_temp_coeffs[31]}}, i_temp_coeffs[31:16]};
    assign t3 = {{16{i_temp_coeffs[47]}}, i_temp_coeffs[47:32]};

    assign ta = {15'd0, i_raw_t[19:3]} - (t1 << 1);
    assign tb = {16'd0, i_raw_t[19:4]} - t1;

    // Fine temperature and hundredths of a degree
    assign tf = r2_a + asr32(r2_bm, 14);
    assign tc = asr32(tf + (tf << 2) + T_RND, 8);

    // Hold the pipe only when the last stage cannot enter the queue
    assign en      = !r_v3 || !i_full;
    assign o_stall = !en;
    assign o_push  = r_v3 && !i_full;
    assign o_item  = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_am  <= ta * t2;
            r1_bsq <= tb * tb;
            r1_p   <= i_raw_p;
            r1_h   <= i_raw_h;

            r2_a   <= asr32(r1_am, 11);
            r2_bm  <= asr32(r1_bsq, 12) * t3;
            r2_p   <= r1_p;
            r2_h   <= r1_h;

            r3_item.fine_t <= tf;
            r3_item.temp_c <= tc[23:0];
            r3_item.raw_p  <= r2_p;
            r3_item.raw_h  <= r2_h;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/pthc_back.sv
`default_nettype none
module pthc_back import pthc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_pop,
    input  t_item              i_item,
    input  logic [63:0]        i_press_lo,
    input  logic [63:0]        i_press_hi,
    input  logic [47:0]        i_press_hum,
    input  logic [31:0]        i_hum,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_fine_temperature,
    output logic signed [23:0] o_temperature_centi,
    output logic [31:0]        o_pressure_q24_8,
    output logic               o_pressure_invalid,
    output logic [16:0]        o_humidity_q22_10
);

    // Stage numbers, stage 1 takes the queue head
    localparam int unsigned ST_SQ      = 1 + MUL_LAT;
    localparam int unsigned ST_A1      = ST_SQ + MUL_LAT;
    localparam int unsigned ST_V2      = ST_A1 + 1;
    localparam int unsigned ST_E       = ST_V2 + MUL_LAT;
    localparam int unsigned ST_DIV_IN  = ST_E + 1;
    localparam int unsigned ST_DIV_OUT = ST_DIV_IN + DIV_LAT;
    localparam int unsigned ST_QQ      = ST_DIV_OUT + MUL_LAT;
    localparam int unsigned ST_CC      = ST_QQ + MUL_LAT;
    localparam int unsigned ST_SUM     = ST_CC + 1;
    localparam int unsigned ST_OUT     = ST_SUM + 1;
    localparam int unsigned ST_HUM     = 8;

    logic        en;
    logic [ST_OUT:1] r_vld;

    // Coefficients
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;

    // Pressure path
    logic [63:0] r_v1;
    logic [63:0] r_pp  [1:ST_V2];
    logic [63:0] r_b1  [ST_SQ+1:ST_A1];
    logic [63:0] r_d1  [ST_SQ+1:ST_A1];
    logic [63:0] r_v2;
    logic [63:0] r_v1b;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic        r_inv [ST_DIV_IN:ST_OUT-1];
    logic [63:0] r_p   [ST_DIV_OUT+1:ST_CC];
    logic [63:0] r_dd  [ST_QQ+1:ST_CC];
    logic [63:0] r_sum;
    logic [63:0] w_sq, w_b1, w_d1, w_a1, w_c1, w_e, w_num, w_quo, w_q, w_qq, w_dd, w_cc;
    logic [63:0] w_pt;
    logic [31:0] w_press;

    // Humidity path
    logic [15:0] r_h   [1:2];
    logic [31:0] r_h1_w1;
    logic [31:0] r_h2_m5, r_h2_m6, r_h2_m3;
    logic [31:0] r_h3_w5, r_h3_m;
    logic [31:0] r_h4_w5, r_h4_m;
    logic [31:0] r_h5_w3;
    logic [31:0] r_h6_w3, r_h6_ss;
    logic [31:0] r_h7_w3, r_h7_m;
    logic [16:0] r_hum [ST_HUM:ST_OUT-1];
    logic [31:0] w_h3_w5;
    logic [31:0] w_h4_w4;
    logic [31:0] w_h6_s;
    logic [31:0] w_h8_w;
    logic [16:0] w_hum;

    // Temperature carried to the output
    logic [31:0] r_tf [1:ST_OUT-1];
    logic [23:0] r_tc [1:ST_OUT-1];

    // Output register
    logic [31:0] r_o_tf;
    logic [23:0] r_o_tc;
    logic [31:0] r_o_press;
    logic        r_o_inv;
    logic [16:0] r_o_hum;

    assign p1 = {48'd0, i_press_lo[15:0]};
    assign p2 = {{48{i_press_lo[31]}}, i_press_lo[31:16]};
    assign p3 = {{48{i_press_lo[47]}}, i_press_lo[47:32]};
    assign p4 = {{48{i_press_lo[63]}}, i_press_lo[63:48]};
    assign p5 = {{48{i_press_hi[15]}}, i_press_hi[15:0]};
    assign p6 = {{48{i_press_hi[31]}}, i_press_hi[31:16]};
    assign p7 = {{48{i_press_hi[47]}}, i_press_hi[47:32]};
    assign p8 = {{48{i_press_hi[63]}}, i_press_hi[63:48]};
    assign p9 = {{48{i_press_hum[15]}}, i_press_hum[15:0]};
    assign h1 = {24'd0, i_press_hum[23:16]};
    assign h2 = {{16{i_press_hum[39]}}, i_press_hum[39:24]};
    assign h3 = {24'd0, i_press_hum[47:40]};
    assign h4 = {{20{i_hum[11]}}, i_hum[11:0]};
    assign h5 = {{20{i_hum[23]}}, i_hum[23:12]};
    assign h6 = {{24{i_hum[31]}}, i_hum[31:24]};

    // Whole pipe holds while a finished result waits
    assign en    = !(r_vld[ST_OUT] && i_stall);
    assign o_pop = en && i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-1:1], i_valid};
        end
    end

    // Dedicated 64-bit multipliers, one per product
    pthc_mul64 u_sq  (.i_clk, .i_en(en), .i_a(r_v1), .i_b(r_v1), .o_p(w_sq));
    pthc_mul64 u_b1  (.i_clk, .i_en(en), .i_a(r_v1), .i_b(p5),   .o_p(w_b1));
    pthc_mul64 u_d1  (.i_clk, .i_en(en), .i_a(r_v1), .i_b(p2),   .o_p(w_d1));
    pthc_mul64 u_a1  (.i_clk, .i_en(en), .i_a(w_sq), .i_b(p6),   .o_p(w_a1));
    pthc_mul64 u_c1  (.i_clk, .i_en(en), .i_a(w_sq), .i_b(p3),   .o_p(w_c1));
    pthc_mul64 u_e   (.i_clk, .i_en(en), .i_a(r_v1b + P_BIAS), .i_b(p1), .o_p(w_e));
    pthc_mul64 u_num (.i_clk, .i_en(en), .i_a((r_pp[ST_V2] << 31) - r_v2),
                      .i_b(P_SCALE), .o_p(w_num));

    pthc_div u_div (.i_clk, .i_en(en), .i_num(r_num), .i_den(r_den), .o_quo(w_quo));

    assign w_q = asr64(w_quo, 13);
    pthc_mul64 u_qq  (.i_clk, .i_en(en), .i_a(w_q),   .i_b(w_q), .o_p(w_qq));
    pthc_mul64 u_dd  (.i_clk, .i_en(en), .i_a(w_quo), .i_b(p8),  .o_p(w_dd));
    pthc_mul64 u_cc  (.i_clk, .i_en(en), .i_a(w_qq),  .i_b(p9),  .o_p(w_cc));

    // Final pressure: round toward zero, add offset, saturate
    assign w_pt = tdiv64(r_sum, 8) + (p7 << 4);
    always_comb begin
        if (w_pt[63]) begin
            w_press = '0;
        end else if (w_pt[62:32] != '0) begin
            w_press = '1;
        end else begin
            w_press = w_pt[31:0];
        end
    end

    // Humidity combinational steps
    assign w_h3_w5 = asr32(({16'd0, r_h[2]} << 14) - (h4 << 20) - r_h2_m5 + H_RND, 15);
    assign w_h4_w4 = asr32(r_h3_m, 10) + H_ADD;
    assign w_h6_s  = asr32(r_h5_w3, 15);
    assign w_h8_w  = r_h7_w3 - tdiv32(r_h7_m, 4);
    always_comb begin
        if (w_h8_w[31]) begin
            w_hum = '0;
        end else if (w_h8_w > H_MAX) begin
            w_hum = H_MAX[28:12];
        end else begin
            w_hum = w_h8_w[28:12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // Enter from the queue
            r_v1    <= {{32{i_item.fine_t[31]}}, i_item.fine_t} - P_T_OFS;
            r_pp[1] <= P_FULL - {44'd0, i_item.raw_p};
            r_tf[1] <= i_item.fine_t;
            r_tc[1] <= i_item.temp_c;
            r_h[1]  <= i_item.raw_h;
            r_h1_w1 <= i_item.fine_t - H_T_OFS;

            // Carry side values
            for (int s = 2; s <= ST_V2; s++) r_pp[s] <= r_pp[s-1];
            for (int s = 2; s <= ST_OUT-1; s++) begin
                r_tf[s] <= r_tf[s-1];
                r_tc[s] <= r_tc[s-1];
            end
            r_h[2] <= r_h[1];
            r_b1[ST_SQ+1] <= w_b1;
            r_d1[ST_SQ+1] <= w_d1;
            for (int s = ST_SQ+2; s <= ST_A1; s++) begin
                r_b1[s] <= r_b1[s-1];
                r_d1[s] <= r_d1[s-1];
            end

            // Pressure terms
            r_v2  <= w_a1 + (r_b1[ST_A1] << 17) + (p4 << 35);
            r_v1b <= tdiv64(w_c1, 8) + (r_d1[ST_A1] << 12);
            r_num <= w_num;
            r_den <= asr64(w_e, 33);
            r_inv[ST_DIV_IN] <= (asr64(w_e, 33) == '0);
            for (int s = ST_DIV_IN+1; s <= ST_OUT-1; s++) r_inv[s] <= r_inv[s-1];
            r_p[ST_DIV_OUT+1] <= w_quo;
            for (int s = ST_DIV_OUT+2; s <= ST_CC; s++) r_p[s] <= r_p[s-1];
            r_dd[ST_QQ+1] <= w_dd;
            for (int s = ST_QQ+2; s <= ST_CC; s++) r_dd[s] <= r_dd[s-1];
            r_sum <= r_p[ST_CC] + asr64(w_cc, 25) + asr64(r_dd[ST_CC], 19);

            // Humidity chain, one multiply per stage but three in the second stage
            r_h2_m5 <= h5 * r_h1_w1;
            r_h2_m6 <= r_h1_w1 * h6;
            r_h2_m3 <= r_h1_w1 * h3;
            r_h3_w5 <= w_h3_w5;
            r_h3_m  <= asr32(r_h2_m6, 10) * (asr32(r_h2_m3, 11) + H_MID);
            r_h4_w5 <= r_h3_w5;
            r_h4_m  <= w_h4_w4 * h2 + H_RND2;
            r_h5_w3 <= r_h4_w5 * asr32(r_h4_m, 14);
            r_h6_w3 <= r_h5_w3;
            r_h6_ss <= w_h6_s * w_h6_s;
            r_h7_w3 <= r_h6_w3;
            r_h7_m  <= tdiv32(r_h6_ss, 7) * h1;
            r_hum[ST_HUM] <= w_hum;
            for (int s = ST_HUM+1; s <= ST_OUT-1; s++) r_hum[s] <= r_hum[s-1];

            // Output register
            r_o_tf    <= r_tf[ST_OUT-1];
            r_o_tc    <= r_tc[ST_OUT-1];
            r_o_inv   <= r_inv[ST_OUT-1];
            r_o_press <= r_inv[ST_OUT-1] ? '0 : w_press;
            r_o_hum   <= r_hum[ST_OUT-1];
        end
    end

    assign o_valid             = r_vld[ST_OUT];
    assign o_fine_temperature  = $signed(r_o_tf);
    assign o_temperature_centi = $signed(r_o_tc);
    assign o_pressure_q24_8    = r_o_press;
    assign o_pressure_invalid  = r_o_inv;
    assign o_humidity_q22_10   = r_o_hum;

    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_pressure_invalid |-> o_pressure_q24_8 == '0)
        else $error("invalid pressure not forced to zero");

endmodule
`default_nettype wire

FILE: hw/rtl/pth_sensor_compensation.sv
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  raw temperature, pressure, humidity
// output    out        o_valid / i_stall  fine temp, centi temp, pressure, flag, humidity
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while i_stall is low; an item passes the temperature
// front, the queue and the back, whose depth is set by the 64-step divider.
// Synchronous active-low reset clears valid state and coefficient registers.
// An output stall freezes the back; the front keeps taking items until the
// queue between them fills.
module pth_sensor_compensation import pthc_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [19:0]          i_raw_temperature,
    input  logic [19:0]          i_raw_pressure,
    input  logic [15:0]          i_raw_humidity,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_fine_temperature,
    output logic signed [23:0]   o_temperature_centi,
    output logic [31:0]          o_pressure_q24_8,
    output logic                 o_pressure_invalid,
    output logic [16:0]          o_humidity_q22_10
);

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [47:0] r_press_hum;
    logic [31:0] r_hum;

    logic  push;
    logic  full;
    logic  pop;
    logic  nempty;
    t_item f_item;
    t_item q_item;

    // Decode coefficient writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_lo    <= '0;
            r_press_hi    <= '0;
            r_press_hum   <= '0;
            r_hum         <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TEMP:      r_temp_coeffs <= i_cfg_data[47:0];
                REG_PRESS_LO:  r_press_lo    <= i_cfg_data;
                REG_PRESS_HI:  r_press_hi    <= i_cfg_data;
                REG_PRESS_HUM: r_press_hum   <= i_cfg_data[47:0];
                REG_HUM:       r_hum         <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    pthc_front u_front (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_stall,
        .i_raw_t       (i_raw_temperature),
        .i_raw_p       (i_raw_pressure),
        .i_raw_h       (i_raw_humidity),
        .i_temp_coeffs (r_temp_coeffs),
        .o_push        (push),
        .i_full        (full),
        .o_item        (f_item)
    );

    pthc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk,
        .i_rst_n,
        .i_push   (push),
        .i_item   (f_item),
        .o_full   (full),
        .i_pop    (pop),
        .o_nempty (nempty),
        .o_item   (q_item)
    );

    pthc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_valid     (nempty),
        .o_pop       (pop),
        .i_item      (q_item),
        .i_press_lo  (r_press_lo),
        .i_press_hi  (r_press_hi),
        .i_press_hum (r_press_hum),
        .i_hum       (r_hum),
        .o_valid,
        .i_stall,
        .o_fine_temperature,
        .o_temperature_centi,
        .o_pressure_q24_8,
        .o_pressure_invalid,
        .o_humidity_q22_10
    );

endmodule
`default_nettype wire
